// ===== rtl/assert_macros.svh =====
// assertion macros shared by the transcoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked while out of reset
`define U8_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// checked at every edge, reset included
`define U8_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define U8_ASSERT(lbl, clk, rst_n, prop)
`define U8_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/u8t16_pkg.sv =====
// types, constants and lead byte table of the utf-8 transcoder
`default_nettype none

package u8t16_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 31;
    localparam int LEFT_W = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register word index
    localparam logic REG_OUTPUT_FORMAT = 1'b0;

    // output_format codes
    localparam logic FMT_UTF16 = 1'b0;
    localparam logic FMT_CODEPOINT = 1'b1;

    localparam logic [BYTE_W-1:0] CONT_TOP_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TOP_CODE = 8'h80;
    localparam logic [CODE_W-1:0] SUPP_BASE = 31'h0001_0000;
    localparam logic [CODE_W-1:0] MAX_CODE = 31'h0010_FFFF;
    localparam logic [5:0] HI_SURR_TAG = 6'b110110;   // 0xd800 >> 10
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;   // 0xdc00 >> 10

    typedef struct packed {
        logic [LEFT_W-1:0] left;   // continuation bytes to follow
        logic [BYTE_W-1:0] mask;   // payload bits of the lead byte
    } t_lead;

    // one finished character as handed to the emitter
    typedef struct packed {
        logic [CODE_W-1:0] code;   // code value, or offset above 0x10000 for a pair
        logic              err;
        logic              last_of_str;
        logic              pair;
    } t_char;

    function automatic t_lead lead_decode(input logic [BYTE_W-1:0] b);
        t_lead r;
        if (b < 8'h80) begin
            r = '{left: 3'd0, mask: 8'h7F};
        end else if (b < 8'hC0) begin
            r = '{left: 3'd0, mask: 8'h00};
        end else if (b < 8'hE0) begin
            r = '{left: 3'd1, mask: 8'h1F};
        end else if (b < 8'hF0) begin
            r = '{left: 3'd2, mask: 8'h0F};
        end else if (b < 8'hF8) begin
            r = '{left: 3'd3, mask: 8'h07};
        end else if (b < 8'hFC) begin
            r = '{left: 3'd4, mask: 8'h03};
        end else if (b < 8'hFE) begin
            r = '{left: 3'd5, mask: 8'h01};
        end else begin
            r = '{left: 3'd0, mask: 8'h00};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/u8t16_if.sv =====
// request channels of the transcoder: byte input and code output
`default_nettype none

interface u8t16_in_if;
    import u8t16_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface u8t16_out_if;
    import u8t16_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_value;
    logic              is_error;
    logic              is_end;
    logic              last;

    modport source (output valid, output code_value, output is_error, output is_end,
                    output last, input ready);
    modport sink (input valid, input code_value, input is_error, input is_end,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/u8t16_step.sv =====
// per byte decode: character state and classification of a finished character
`default_nettype none

module u8t16_step (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_buffer_end,
    input  wire logic             i_output_format,
    output logic                  o_char_valid,
    output u8t16_pkg::t_char      o_char
);
    import u8t16_pkg::*;

    `include "assert_macros.svh"

    logic [CODE_W-1:0] r_part, n_part;
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_bad, n_bad;

    t_lead             lead;
    logic              done;
    logic [19:0]       supp_off;

    always_comb begin
        lead = lead_decode(i_data_byte);
        if (r_left == '0) begin
            n_part = {{(CODE_W-BYTE_W){1'b0}}, i_data_byte & lead.mask};
            n_bad = 1'b0;
            n_left = lead.left;
            done = (lead.left == '0);
        end else begin
            if ((i_data_byte & CONT_TOP_MASK) != CONT_TOP_CODE) begin
                n_part = r_part;
                n_bad = 1'b1;
            end else begin
                n_part = {r_part[CODE_W-7:0], i_data_byte[5:0]};
                n_bad = r_bad;
            end
            n_left = r_left - 3'd1;
            done = (n_left == '0);
        end

        // offset above 0x10000 of the finished code point, used for a pair
        supp_off = n_part[19:0] - SUPP_BASE[19:0];

        // classify from the updated state
        o_char = '{code: '0, err: 1'b0, last_of_str: i_buffer_end, pair: 1'b0};
        o_char_valid = i_accept && (done || i_buffer_end);
        if (!done) begin
            o_char.err = 1'b1;   // truncated by end of buffer
        end else if (n_bad) begin
            o_char.err = 1'b1;
        end else if (n_part == '0) begin
            o_char.last_of_str = 1'b1;   // nul or stray continuation
        end else if (i_output_format == FMT_CODEPOINT || n_part < SUPP_BASE) begin
            o_char.code = n_part;
        end else if (n_part > MAX_CODE) begin
            o_char.err = 1'b1;
        end else begin
            o_char.code = {{(CODE_W-20){1'b0}}, supp_off};
            o_char.pair = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= '0;
            r_left <= '0;
            r_bad  <= 1'b0;
        end else if (i_accept) begin
            if (done || i_buffer_end) begin
                r_part <= '0;
                r_left <= '0;
                r_bad  <= 1'b0;
            end else begin
                r_part <= n_part;
                r_left <= n_left;
                r_bad  <= n_bad;
            end
        end
    end

    `U8_ASSERT(a_left_range, i_clk, i_rst_n, r_left <= 3'd5)
    `U8_ASSERT(a_idle_clear, i_clk, i_rst_n, r_left == '0 |-> r_part == '0 && !r_bad)
    `U8_ASSERT(a_pair_in_range, i_clk, i_rst_n, o_char_valid && o_char.pair |-> !o_char.err && o_char.code[CODE_W-1:20] == '0)

endmodule

`default_nettype wire

// ===== rtl/u8t16_emit.sv =====
// character holding register and output register, splits surrogate pairs
`default_nettype none

module u8t16_emit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_char_valid,
    input  wire u8t16_pkg::t_char i_char,
    output logic                  o_in_ready,
    u8t16_out_if.source           o_out
);
    import u8t16_pkg::*;

    `include "assert_macros.svh"

    t_char             r_rec;
    logic              r_av;
    logic              r_second;
    logic              r_ov;
    logic [CODE_W-1:0] r_code, n_code;
    logic              r_err, n_err;
    logic              r_end, n_end;
    logic              r_last, n_last;

    logic out_free, a_move, a_done;

    always_comb begin
        out_free = !r_ov || o_out.ready;
        a_move = r_av && out_free;
        a_done = a_move && (!r_rec.pair || r_second);
        o_in_ready = !r_av || a_done;

        n_code = r_rec.code;
        n_err  = r_rec.err;
        n_end  = r_rec.last_of_str;
        n_last = 1'b1;
        if (r_rec.pair) begin
            n_err = 1'b0;
            if (!r_second) begin
                n_code = {{(CODE_W-16){1'b0}}, HI_SURR_TAG, r_rec.code[19:10]};
                n_end  = 1'b0;
                n_last = 1'b0;
            end else begin
                n_code = {{(CODE_W-16){1'b0}}, LO_SURR_TAG, r_rec.code[9:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av     <= 1'b0;
            r_second <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_char_valid) begin
                r_av <= 1'b1;
            end else if (a_done) begin
                r_av <= 1'b0;
            end
            if (a_done) begin
                r_second <= 1'b0;
            end else if (a_move) begin
                r_second <= 1'b1;
            end
            if (a_move) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char_valid) begin
            r_rec <= i_char;
        end
        if (a_move) begin
            r_code <= n_code;
            r_err  <= n_err;
            r_end  <= n_end;
            r_last <= n_last;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.code_value = r_code;
    assign o_out.is_error   = r_err;
    assign o_out.is_end     = r_end;
    assign o_out.last       = r_last;

    `U8_ASSERT(a_second_held, i_clk, i_rst_n, r_second |-> r_av && r_rec.pair)
    `U8_ASSERT(a_high_unit_pending, i_clk, i_rst_n, r_ov && !r_last |-> r_av && r_second)
    `U8_ASSERT(a_error_zero, i_clk, i_rst_n, r_ov && r_err |-> r_code == '0)
    `U8_ASSERT_ALWAYS(a_no_overwrite, i_clk, i_char_valid |-> o_in_ready)

endmodule

`default_nettype wire

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// top level of the utf-8 to utf-16 / code point transcoder
//
// usage
//   i_in carries one utf-8 byte per request (data_byte, buffer_end); o_out
//   carries result requests (code_value, is_error, is_end, last). both use
//   valid/ready; a request moves on a clock edge with valid and ready high.
//   output_format sits at byte address 0 of the apb port (0: utf-16 code
//   units, 1: whole code points); write it only while the block is idle.
// flow and throughput
//   a finished character is written to the character register by the edge
//   that takes its last byte, then to the output register when it is free.
//   one byte is taken every cycle while o_out.ready is high; a surrogate
//   pair holds the character register and keeps i_in.ready low until its
//   low unit moves on. bytes inside a character give no result and still go at one per cycle.
// reset
//   synchronous active-low reset clears the character state, both
//   pipeline valids and output_format (utf-16 mode).
// stall
//   with o_out.ready low the output register holds; one more finished
//   character waits in the character register, then i_in.ready drops.
`default_nettype none

module utf8_to_utf16_transcoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // apb configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [u8t16_pkg::PADDR_W-1:0] paddr,
    input  wire logic [u8t16_pkg::PDATA_W-1:0] pwdata,
    output logic      [u8t16_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    // byte requests in, result requests out
    u8t16_in_if.sink                         i_in,
    u8t16_out_if.source                      o_out
);
    import u8t16_pkg::*;

    logic   r_output_format;
    logic   cfg_wr;
    logic   in_ready;
    logic   accept;
    logic   char_valid;
    t_char  char_rec;

    // apb: zero wait states, word index in paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_OUTPUT_FORMAT: prdata = {{(PDATA_W-1){1'b0}}, r_output_format};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_format <= FMT_UTF16;
        end else if (cfg_wr && paddr[2] == REG_OUTPUT_FORMAT) begin
            r_output_format <= pwdata[0];
        end
    end

    // a byte is taken whenever the character register is free or draining
    assign i_in.ready = in_ready;
    assign accept = i_in.valid && in_ready;

    // stage one: lead/continuation decode and character classification
    u8t16_step u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_in.data_byte),
        .i_buffer_end    (i_in.buffer_end),
        .i_output_format (r_output_format),
        .o_char_valid    (char_valid),
        .o_char          (char_rec)
    );

    // stage two: character register, surrogate split, output register
    u8t16_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (char_valid),
        .i_char       (char_rec),
        .o_in_ready   (in_ready),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

// ===== tb/sv/u8t16_checker.sv =====
// scoreboard for the utf-8 transcoder: tracks the register, predicts results, compares
`timescale 1ns / 1ps

module u8t16_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u8t16_pkg::PADDR_W-1:0] paddr,
    input  logic [u8t16_pkg::PDATA_W-1:0] pwdata,
    input  logic [u8t16_pkg::PDATA_W-1:0] prdata,
    input  logic                          pready,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [u8t16_pkg::BYTE_W-1:0]  in_byte,
    input  logic                          in_end,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [u8t16_pkg::CODE_W-1:0]  out_code,
    input  logic                          out_err,
    input  logic                          out_end,
    input  logic                          out_last,
    output int                            fail_count,
    output int                            codes_due,
    output int                            codes_checked,
    output int                            pairs_checked,
    output int                            errors_checked,
    output int                            ends_checked
);
    import u8t16_pkg::*;

    localparam logic [PADDR_W-1:0] FMT_ADDR = PADDR_W'(4 * REG_OUTPUT_FORMAT);
    localparam logic [1:0] CONT_PREFIX = 2'b10;
    localparam logic [CODE_W-1:0] PLANE1_FIRST = 31'h0001_0000;
    localparam logic [CODE_W-1:0] PLANE16_LAST = 31'h0010_FFFF;
    localparam logic [CODE_W-1:0] HIGH_UNIT_BASE = 31'h0000_D800;
    localparam logic [CODE_W-1:0] LOW_UNIT_BASE = 31'h0000_DC00;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              err;
        logic              str_end;
        logic              last_unit;
    } t_code_rec;

    t_code_rec          due_codes[$];
    logic [CODE_W-1:0]  gathered;
    logic [LEFT_W-1:0]  bytes_owed;
    logic               char_flawed;
    logic               out_format;
    int                 mismatches;

    assign fail_count = mismatches;

    task automatic push_code(input logic [CODE_W-1:0] code, input logic err,
                             input logic str_end, input logic last_unit);
        due_codes.push_back('{code: code, err: err, str_end: str_end, last_unit: last_unit});
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic buf_end);
        logic [LEFT_W-1:0] span;
        logic [BYTE_W-1:0] keep;
        logic              done;
        logic [CODE_W-1:0] cp;
        logic [CODE_W-1:0] offset;
        logic              flawed;
        if (bytes_owed == '0) begin
            casez (b)
                8'b0???????: begin span = 3'd1; keep = 8'h7F; end
                8'b10??????: begin span = 3'd1; keep = 8'h00; end
                8'b110?????: begin span = 3'd2; keep = 8'h1F; end
                8'b1110????: begin span = 3'd3; keep = 8'h0F; end
                8'b11110???: begin span = 3'd4; keep = 8'h07; end
                8'b111110??: begin span = 3'd5; keep = 8'h03; end
                8'b1111110?: begin span = 3'd6; keep = 8'h01; end
                default: begin span = 3'd1; keep = 8'h00; end
            endcase
            gathered = CODE_W'(b & keep);
            char_flawed = 1'b0;
            bytes_owed = span - 3'd1;
            done = (span == 3'd1);
        end else begin
            if (b[7:6] != CONT_PREFIX) begin
                char_flawed = 1'b1;
            end else begin
                gathered = {gathered[CODE_W-7:0], b[5:0]};
            end
            bytes_owed = bytes_owed - 3'd1;
            done = (bytes_owed == '0);
        end

        if (!done) begin
            // truncated by the end of the buffer
            if (buf_end) begin
                gathered = '0;
                bytes_owed = '0;
                char_flawed = 1'b0;
                push_code('0, 1'b1, 1'b1, 1'b1);
            end
            return;
        end

        cp = gathered;
        flawed = char_flawed;
        gathered = '0;
        char_flawed = 1'b0;

        if (flawed) begin
            push_code('0, 1'b1, buf_end, 1'b1);
        end else if (cp == '0) begin
            push_code('0, 1'b0, 1'b1, 1'b1);
        end else if (out_format == FMT_CODEPOINT || cp < PLANE1_FIRST) begin
            push_code(cp, 1'b0, buf_end, 1'b1);
        end else if (cp > PLANE16_LAST) begin
            push_code('0, 1'b1, buf_end, 1'b1);
        end else begin
            offset = cp - PLANE1_FIRST;
            push_code(HIGH_UNIT_BASE + CODE_W'(offset[19:10]), 1'b0, 1'b0, 1'b0);
            push_code(LOW_UNIT_BASE + CODE_W'(offset[9:0]), 1'b0, buf_end, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_code_rec want;
        if (!i_rst_n) begin
            due_codes.delete();
            gathered = '0;
            bytes_owed = '0;
            char_flawed = 1'b0;
            out_format = FMT_UTF16;
            mismatches = 0;
            codes_checked = 0;
            pairs_checked = 0;
            errors_checked = 0;
            ends_checked = 0;
            codes_due <= 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == FMT_ADDR) begin
                        out_format = pwdata[0];
                    end
                end else if (paddr == FMT_ADDR && prdata != PDATA_W'(out_format)) begin
                    $error("output_format read: expected %0h, got %0h", out_format, prdata);
                    mismatches++;
                end
            end

            if (out_valid && out_ready) begin
                if (due_codes.size() == 0) begin
                    $error("result with no expected value: code_value %0h", out_code);
                    mismatches++;
                end else begin
                    want = due_codes.pop_front();
                    codes_checked++;
                    if (!want.last_unit) pairs_checked++;
                    if (want.err) errors_checked++;
                    if (want.str_end) ends_checked++;
                    if (out_code != want.code) begin
                        $error("code_value: expected %0h, got %0h", want.code, out_code);
                        mismatches++;
                    end
                    if (out_err != want.err) begin
                        $error("is_error: expected %0b, got %0b", want.err, out_err);
                        mismatches++;
                    end
                    if (out_end != want.str_end) begin
                        $error("is_end: expected %0b, got %0b", want.str_end, out_end);
                        mismatches++;
                    end
                    if (out_last != want.last_unit) begin
                        $error("last: expected %0b, got %0b", want.last_unit, out_last);
                        mismatches++;
                    end
                end
            end

            if (in_valid && in_ready) begin
                decode_byte(in_byte, in_end);
            end
            codes_due <= due_codes.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// top of the transcoder testbench: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import u8t16_pkg::*;

    localparam logic [PADDR_W-1:0] FMT_ADDR = PADDR_W'(4 * REG_OUTPUT_FORMAT);
    localparam int PHASES = 6;
    localparam int PHASE_BYTES = 300;
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;      // settling margin after the last expected result
    localparam int WATCHDOG_LIMIT = 5000; // cycles without any accepted request

    typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_BURSTY} t_rx_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    u8t16_in_if  in_ch ();
    u8t16_out_if out_ch ();

    int       fail_count;
    int       codes_due;
    int       codes_checked;
    int       pairs_checked;
    int       errors_checked;
    int       ends_checked;
    int       bytes_sent;
    int       burst_left;
    int       idle_cycles;
    bit       tx_gaps;
    bit       hold_off_req;
    t_rx_mode rx_mode;

    utf8_to_utf16_transcoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    u8t16_checker scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .in_byte        (in_ch.data_byte),
        .in_end         (in_ch.buffer_end),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_code       (out_ch.code_value),
        .out_err        (out_ch.is_error),
        .out_end        (out_ch.is_end),
        .out_last       (out_ch.last),
        .fail_count     (fail_count),
        .codes_due      (codes_due),
        .codes_checked  (codes_checked),
        .pairs_checked  (pairs_checked),
        .errors_checked (errors_checked),
        .ends_checked   (ends_checked)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake or a missing result stops the run here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d results still expected", codes_due);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver: stall pattern set per phase, plus one long hold-off on request
    initial begin : receiver
        int  run;
        bit  stalled;
        run = 0;
        stalled = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                // keep the output blocked so the block backs up into its input
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            case (rx_mode)
                RX_STEADY: out_ch.ready <= 1'b1;
                RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    // alternating runs of ready and stall of random length
                    if (run == 0) begin
                        run = $urandom_range(1, 12);
                        stalled = ~stalled;
                    end
                    out_ch.ready <= ~stalled;
                    run--;
                end
            endcase
            @(posedge i_clk);
        end
    end

    // one apb transfer: setup cycle, then access until pready
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // offer one byte request; the sender runs in bursts, with random gaps between when tx_gaps is set
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic buf_end);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = tx_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.buffer_end <= buf_end;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // one character: mostly well formed with random payload, some with a bad
    // continuation, some cut short by the buffer end, the rest random noise
    task automatic send_char();
        logic [BYTE_W-1:0] seq [6];
        logic [BYTE_W-1:0] bad_byte;
        int                kind;
        int                roll;
        int                span;
        int                cut;
        int                pos;
        kind = $urandom_range(0, 99);
        if (kind >= 88) begin
            send_byte(BYTE_W'($urandom()), $urandom_range(0, 7) == 0);
            return;
        end
        roll = $urandom_range(0, 99);
        span = (roll < 30) ? 1 : (roll < 50) ? 2 : (roll < 65) ? 3 :
               (roll < 85) ? 4 : (roll < 93) ? 5 : 6;
        case (span)
            1: seq[0] = ($urandom_range(0, 19) == 0) ? 8'h00 : BYTE_W'($urandom_range(1, 127));
            2: seq[0] = 8'hC0 | BYTE_W'($urandom_range(0, 31));
            3: seq[0] = 8'hE0 | BYTE_W'($urandom_range(0, 15));
            4: seq[0] = 8'hF0 | BYTE_W'($urandom_range(0, 7));
            5: seq[0] = 8'hF8 | BYTE_W'($urandom_range(0, 3));
            default: seq[0] = 8'hFC | BYTE_W'($urandom_range(0, 1));
        endcase
        for (int k = 1; k < span; k++) begin
            seq[k] = 8'h80 | BYTE_W'($urandom_range(0, 63));
        end
        // bad continuation somewhere inside the character
        if (kind >= 72 && span > 1) begin
            bad_byte = BYTE_W'($urandom());
            while (bad_byte[7:6] == 2'b10) bad_byte = BYTE_W'($urandom());
            pos = $urandom_range(1, span - 1);
            seq[pos] = bad_byte;
        end
        // occasionally the buffer ends before the character is complete
        cut = (span > 1 && $urandom_range(0, 24) == 0) ? $urandom_range(0, span - 2) : span - 1;
        for (int k = 0; k <= cut; k++) begin
            send_byte(seq[k], (k == cut) && (cut < span - 1 || $urandom_range(0, 9) == 0));
        end
    endtask

    // let every expected result come out, then give the pipeline time to settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (codes_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int  phase_start;
        bit  hold_done;
        logic fmt;

        // every input known from time zero
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.buffer_end <= 1'b0;
        bytes_sent = 0;
        burst_left = 0;
        tx_gaps = 1'b1;
        hold_off_req = 1'b0;
        hold_done = 1'b0;
        rx_mode = RX_RANDOM;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, utf-16 mode straight out of reset
        send_byte(8'h41, 1'b1);                          // ascii closing its buffer
        send_byte(8'hC3, 1'b0);                          // two byte character
        send_byte(8'hA9, 1'b0);
        send_byte(8'hF0, 1'b0);                          // surrogate pair, end on low unit
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hF4, 1'b0);                          // above 0x10ffff, flagged
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0);                          // lone surrogate passes as one unit
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC3, 1'b0);                          // bad continuation
        send_byte(8'h41, 1'b0);
        send_byte(8'h80, 1'b0);                          // stray continuation ends the string
        send_byte(8'h00, 1'b0);                          // nul ends the string
        send_byte(8'hFF, 1'b0);                          // lead with no payload decodes to zero
        send_byte(8'hE2, 1'b0);                          // truncated by buffer end
        send_byte(8'h82, 1'b1);

        // whole code points: the largest six byte value
        drain();
        apb_access(1'b1, FMT_ADDR, PDATA_W'(FMT_CODEPOINT));
        apb_access(1'b0, FMT_ADDR, '0);
        send_byte(8'hFD, 1'b0);
        for (int k = 0; k < 5; k++) send_byte(8'hBF, k == 4);

        // random phases, alternating the output format
        for (int ph = 0; ph < PHASES; ph++) begin
            fmt = (ph % 2 == 0) ? FMT_UTF16 : FMT_CODEPOINT;
            drain();
            apb_access(1'b1, FMT_ADDR, PDATA_W'(fmt));
            apb_access(1'b0, FMT_ADDR, '0);
            // first phase runs with no idling at all on either side
            rx_mode = (ph == 0) ? RX_STEADY : t_rx_mode'($urandom_range(1, 2));
            tx_gaps = (ph != 0);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if (ph == 2 && !hold_done && bytes_sent - phase_start >= 100) begin
                    hold_off_req = 1'b1;
                    hold_done = 1'b1;
                end
                send_char();
            end
        end

        drain();

        $display("covered %0d bytes in both output formats, %0d results checked",
                 bytes_sent, codes_checked);
        $display("results included %0d surrogate pairs, %0d errors, %0d string ends",
                 pairs_checked, errors_checked, ends_checked);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/u8t16_pkg.sv
rtl/u8t16_if.sv
rtl/u8t16_step.sv
rtl/u8t16_emit.sv
rtl/utf8_to_utf16_transcoder.sv
tb/sv/u8t16_checker.sv
tb/sv/tb_top.sv
